### rtl/clce_pkg.sv
// shared types, codes and the init sequence table for the lcd expander encoder
`timescale 1ns / 1ps
`default_nettype none
package clce_pkg;

  // request kinds
  localparam logic [1:0] REQ_INIT = 2'd0;
  localparam logic [1:0] REQ_CMD  = 2'd1;
  localparam logic [1:0] REQ_CURS = 2'd2;
  localparam logic [1:0] REQ_CHAR = 2'd3;

  // sequencing limits
  localparam logic [3:0] LAST_INIT_NIB = 4'd13;
  localparam logic [3:0] LAST_BYTE_NIB = 4'd1;
  localparam logic [1:0] PH_EN_HIGH    = 2'd0;
  localparam logic [1:0] PH_EN_LOW     = 2'd1;
  localparam logic [1:0] PH_END        = 2'd2;

  // row start addresses
  localparam logic [6:0] ROW_OFS_0 = 7'h00;
  localparam logic [6:0] ROW_OFS_1 = 7'h40;
  localparam logic [6:0] ROW_OFS_2 = 7'h14;
  localparam logic [6:0] ROW_OFS_3 = 7'h54;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic       last;
    logic [3:0] nib;
    logic [1:0] ph;
  } clce_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_init;
  } clce_sts_t;

  typedef struct packed {
    logic [3:0] nib;
    logic [6:0] wait_ms;
    logic       ends;
  } clce_init_t;

  function automatic clce_init_t init_step(input logic [3:0] idx);
    clce_init_t t;
    t = '{nib: 4'h0, wait_ms: 7'd0, ends: 1'b0};
    case (idx)
      4'd0, 4'd1, 4'd2: t = '{nib: 4'h3, wait_ms: 7'd5, ends: 1'b1};
      4'd3:  t = '{nib: 4'h2, wait_ms: 7'd5,   ends: 1'b1};
      4'd4:  t = '{nib: 4'h2, wait_ms: 7'd0,   ends: 1'b0};
      4'd5:  t = '{nib: 4'h8, wait_ms: 7'd1,   ends: 1'b1};
      4'd6:  t = '{nib: 4'h0, wait_ms: 7'd0,   ends: 1'b0};
      4'd7:  t = '{nib: 4'h8, wait_ms: 7'd1,   ends: 1'b1};
      4'd8:  t = '{nib: 4'h0, wait_ms: 7'd0,   ends: 1'b0};
      4'd9:  t = '{nib: 4'h1, wait_ms: 7'd100, ends: 1'b1};
      4'd10: t = '{nib: 4'h0, wait_ms: 7'd0,   ends: 1'b0};
      4'd11: t = '{nib: 4'h6, wait_ms: 7'd100, ends: 1'b1};
      4'd12: t = '{nib: 4'h0, wait_ms: 7'd0,   ends: 1'b0};
      4'd13: t = '{nib: 4'hC, wait_ms: 7'd100, ends: 1'b1};
      default: t = '{nib: 4'h0, wait_ms: 7'd0, ends: 1'b0};
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

### rtl/clce_ctrl.sv
// sequencer that walks the nibbles and enable phases of one request
`timescale 1ns / 1ps
`default_nettype none
module clce_ctrl
  import clce_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire clce_sts_t sts_i,
  output clce_cmd_t      cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic       state_q, state_d;
  logic [3:0] nib_q, nib_d;
  logic [1:0] ph_q, ph_d;
  logic       last_step;
  logic       emit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign last_step  = (ph_q == PH_END) &&
                      (nib_q == (sts_i.is_init ? LAST_INIT_NIB : LAST_BYTE_NIB));
  assign emit       = (state_q == ST_RUN) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    nib_d   = nib_q;
    ph_d    = ph_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          nib_d   = 4'd0;
          ph_d    = PH_EN_HIGH;
        end
      end
      ST_RUN: begin
        if (emit) begin
          if (last_step) begin
            state_d = ST_IDLE;
          end else if (ph_q == PH_END) begin
            ph_d  = PH_EN_HIGH;
            nib_d = nib_q + 4'd1;
          end else begin
            ph_d = ph_q + 2'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nib_q   <= 4'd0;
      ph_q    <= PH_EN_HIGH;
    end else begin
      state_q <= state_d;
      nib_q   <= nib_d;
      ph_q    <= ph_d;
    end
  end

  assign cmd_o.load = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.emit = emit;
  assign cmd_o.last = last_step;
  assign cmd_o.nib  = nib_q;
  assign cmd_o.ph   = ph_q;

endmodule
`default_nettype wire

### rtl/clce_dp.sv
// request registers, expander byte assembly and the output register
`timescale 1ns / 1ps
`default_nettype none
module clce_dp
  import clce_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] req_type_i,
  input  wire logic [7:0] value_i,
  input  wire logic [1:0] row_i,
  input  wire logic [4:0] column_i,
  input  wire clce_cmd_t  cmd_i,
  output clce_sts_t       sts_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [6:0]      out_wait_o,
  output logic            out_end_o,
  output logic            out_last_o
);

  logic [1:0] type_q;
  logic [7:0] byte_q;
  logic [6:0] row_ofs;
  logic [6:0] addr;
  logic [7:0] byte_sel;
  clce_init_t init_t;
  logic [3:0] nibble;
  logic       ends;
  logic [6:0] wait_ms;
  logic       rs;
  logic       en;

  logic       valid_q;
  logic [7:0] obyte_q;
  logic [6:0] owait_q;
  logic       oend_q;
  logic       olast_q;

  always_comb begin
    unique case (row_i)
      2'd0:    row_ofs = ROW_OFS_0;
      2'd1:    row_ofs = ROW_OFS_1;
      2'd2:    row_ofs = ROW_OFS_2;
      default: row_ofs = ROW_OFS_3;
    endcase
  end

  // column plus offset never passes 0x73, so seven bits hold it
  assign addr     = {2'b00, column_i} + row_ofs;
  assign byte_sel = (req_type_i == REQ_CURS) ? {1'b1, addr} : value_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q <= req_type_i;
      byte_q <= byte_sel;
    end
  end

  assign init_t = init_step(cmd_i.nib);

  always_comb begin
    if (type_q == REQ_INIT) begin
      nibble  = init_t.nib;
      ends    = init_t.ends && (cmd_i.ph == PH_END);
      wait_ms = ends ? init_t.wait_ms : 7'd0;
    end else begin
      nibble  = cmd_i.nib[0] ? byte_q[3:0] : byte_q[7:4];
      ends    = cmd_i.nib[0] && (cmd_i.ph == PH_END);
      wait_ms = 7'd0;
    end
  end

  assign rs = (type_q == REQ_CHAR);
  assign en = (cmd_i.ph != PH_EN_LOW);

  assign sts_o.out_free = !valid_q || out_ready_i;
  assign sts_o.is_init  = (type_q == REQ_INIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      // backlight always on, read/write always low
      obyte_q <= {nibble, 1'b1, en, 1'b0, rs};
      owait_q <= wait_ms;
      oend_q  <= ends;
      olast_q <= cmd_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = obyte_q;
  assign out_wait_o  = owait_q;
  assign out_end_o   = oend_q;
  assign out_last_o  = olast_q;

  a_last_ends_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && olast_q |-> oend_q)
    else $error("item end without transfer end");

  a_wait_only_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (owait_q != 7'd0) |-> oend_q)
    else $error("wait set inside a transfer");

  a_end_with_enable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && oend_q |-> obyte_q[2] && obyte_q[3] && !obyte_q[1])
    else $error("transfer end byte malformed");

endmodule
`default_nettype wire

### rtl/char_lcd_i2c_expander_encoder_unit.sv
// top level: character lcd request to i2c expander byte stream encoder
//
//   channel   dir  tdata                                 tuser          tlast
//   s_axis    in   value, row, column                    req_type       -
//   m_axis    out  expander_byte, wait_ms                transfer_end   last of item
//
// an item is taken while the sequencer is idle, then one output byte per cycle while m_axis_tready
// is high: six bytes for a command, cursor or character item, forty-two for
// init, counted out by the nibble and phase counters of the sequencer. a new
// item is taken once the previous one has issued all its bytes, even while
// the final byte waits in the output register. reset clears the sequencer and
// the output valid flag. a stall on m_axis holds the sequencer in place.
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_i2c_expander_encoder_unit
  import clce_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // value[7:0], row[9:8], column[14:10], zero[15]
  input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // expander_byte[7:0], wait_ms[14:8], zero[15]
  output logic [0:0]       m_axis_tuser,  // transfer_end[0]
  output logic             m_axis_tlast
);

  clce_cmd_t  cmd;
  clce_sts_t  sts;
  logic [7:0] out_byte;
  logic [6:0] out_wait;
  logic       out_end;

  clce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  clce_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_type_i  (s_axis_tuser),
    .value_i     (s_axis_tdata[7:0]),
    .row_i       (s_axis_tdata[9:8]),
    .column_i    (s_axis_tdata[14:10]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (out_byte),
    .out_wait_o  (out_wait),
    .out_end_o   (out_end),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_wait, out_byte};
  assign m_axis_tuser = out_end;

endmodule
`default_nettype wire
